[rtl/lru_pkg.sv]
// lru_pkg: sizes, codes, types and the per-cell control struct for the LRU tracker.
// Used by the channel interfaces and every rtl module; depends on nothing.
package lru_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int ID_BITS     = 8;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // fixed field widths on the channels and the register
  localparam int ITEM_ID_W  = 8;
  localparam int EVICT_ID_W = 8;
  localparam int OCC_W      = 5;
  localparam int EVCNT_W    = 32;
  localparam int CAP_W      = 5;

  // APB register port
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;
  localparam int REG_IDX_LSB = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // kind codes
  localparam logic KIND_ACCESS = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  // register index (word address bit)
  localparam logic REG_CAPACITY = 1'b0;

  typedef logic [ID_BITS-1:0]    id_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [CAP_W-1:0]      cap_t;
  typedef logic [EVICT_ID_W-1:0] evid_t;
  typedef logic [OCC_W-1:0]      occ_t;
  typedef logic [EVCNT_W-1:0]    evcnt_t;
  typedef logic [APB_DATA_W-1:0] apb_data_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic capture_en;  // latch compare result against id
    logic shift_en;    // shift toward the LRU end from the hit position up
    logic shift_all;   // eviction: every cell shifts
    logic load_en;     // write id into the cell at top_idx
    idx_t top_idx;     // MRU position after this step
    id_t  id;          // compare key / id to load
  } cell_ctrl_t;

endpackage

[rtl/lru_if.sv]
// lru_if: valid/ready channel interfaces for request and result beats.
// Depends on lru_pkg for field widths.
interface lru_in_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic [lru_pkg::ITEM_ID_W-1:0]    item_id;

  modport source (output valid, output kind, output item_id, input ready);
  modport sink   (input valid, input kind, input item_id, output ready);
endinterface

interface lru_out_if;
  logic                             valid;
  logic                             ready;
  logic                             evicted_valid;
  logic [lru_pkg::EVICT_ID_W-1:0]   evicted_id;
  logic                             misuse;
  logic [lru_pkg::OCC_W-1:0]        occupancy;
  logic [lru_pkg::EVCNT_W-1:0]      eviction_count;

  modport source (output valid, output evicted_valid, output evicted_id, output misuse,
                  output occupancy, output eviction_count, input ready);
  modport sink   (input valid, input evicted_valid, input evicted_id, input misuse,
                  input occupancy, input eviction_count, output ready);
endinterface

[rtl/lru_cell.sv]
// lru_cell: one position of the recency row (id, valid, latched match).
// Depends on lru_pkg; neighbors chain through next_id and seen_in/seen_out.
module lru_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  lru_pkg::cell_ctrl_t ctrl,
  input  lru_pkg::idx_t       my_idx,
  input  lru_pkg::id_t        next_id,
  input  logic                seen_in,
  output lru_pkg::id_t        id_q,
  output logic                valid_q,
  output logic                seen_out
);

  lru_pkg::id_t id_r, id_nxt;
  logic         valid_r, valid_nxt;
  logic         match_r, match_nxt;

  assign id_q    = id_r;
  assign valid_q = valid_r;

  always_comb begin
    seen_out  = seen_in | match_r;
    id_nxt    = id_r;
    valid_nxt = valid_r;
    match_nxt = match_r;
    if (ctrl.capture_en) begin
      match_nxt = valid_r && (id_r == ctrl.id);
    end
    if (ctrl.load_en && (my_idx == ctrl.top_idx)) begin
      id_nxt    = ctrl.id;
      valid_nxt = 1'b1;
    end else if (ctrl.shift_en && (seen_out || ctrl.shift_all)) begin
      id_nxt = next_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    id_r    <= id_nxt;
    match_r <= match_nxt;
  end

endmodule

[rtl/lru_cfg.sv]
// lru_cfg: APB-style register file holding the capacity register.
// Depends on lru_pkg.
module lru_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lru_pkg::APB_ADDR_W-1:0]    paddr,
  input  lru_pkg::apb_data_t                pwdata,
  output lru_pkg::apb_data_t                prdata,
  output logic                              pready,
  output lru_pkg::cap_t                     capacity
);

  lru_pkg::cap_t cap_r, cap_nxt;
  logic          wr_en;

  assign pready   = 1'b1;
  assign capacity = cap_r;
  assign wr_en    = psel && penable && pwrite && pready;

  always_comb begin
    cap_nxt = cap_r;
    if (wr_en && (paddr[lru_pkg::REG_IDX_LSB] == lru_pkg::REG_CAPACITY)) begin
      cap_nxt = pwdata[lru_pkg::CAP_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[lru_pkg::REG_IDX_LSB])
      lru_pkg::REG_CAPACITY: prdata = lru_pkg::apb_data_t'(cap_r);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lru_pkg::CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

endmodule

[rtl/lru_replacement_tracker.sv]
// lru_replacement_tracker: top level; LRU recency list as a row of shifting cells.
// Depends on lru_pkg, lru_if (lru_in_if, lru_out_if), lru_cell and lru_cfg.
//
//   channel   dir   beat contents                                   handshake
//   in_ch     in    kind, item_id                                   valid/ready
//   out_ch    out   evicted_valid, evicted_id, misuse, occupancy,   valid/ready
//                   eviction_count
//   cfg       in    capacity register at byte 0                     APB, pready tied high
//
// Each request: the accept edge latches a compare in every cell, then the update state shifts
// the row and loads the new MRU entry in the compare-then-shift cell row.
// Result is held in an output register; a new request is accepted while it waits, but the
// update cycle stalls until that register frees up.
// Reset (rst_n, synchronous) empties the row, clears counts and sets capacity to 16.
// Position 0 is LRU, position occupancy-1 is MRU.
module lru_replacement_tracker (
  input  logic                            clk,
  input  logic                            rst_n,
  lru_in_if.sink                          in_ch,
  lru_out_if.source                       out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lru_pkg::APB_ADDR_W-1:0]  paddr,
  input  lru_pkg::apb_data_t              pwdata,
  output lru_pkg::apb_data_t              prdata,
  output logic                            pready
);

  typedef enum logic {S_IDLE, S_UPD} state_t;

  state_t              state_r, state_nxt;
  logic                req_kind_r, req_kind_nxt;
  lru_pkg::id_t        req_id_r, req_id_nxt;
  lru_pkg::cnt_t       count_r, count_nxt;
  lru_pkg::evcnt_t     evcnt_r, evcnt_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_evv_r, out_evv_nxt;
  lru_pkg::evid_t      out_evid_r, out_evid_nxt;
  logic                out_mis_r, out_mis_nxt;
  lru_pkg::occ_t       out_occ_r, out_occ_nxt;
  lru_pkg::evcnt_t     out_cnt_r, out_cnt_nxt;

  lru_pkg::cap_t       capacity;
  lru_pkg::cnt_t       eff_cap;
  lru_pkg::cell_ctrl_t ctrl;
  lru_pkg::id_t        cell_id [lru_pkg::MAX_ENTRIES];
  logic [lru_pkg::MAX_ENTRIES-1:0] cell_valid;
  logic [lru_pkg::MAX_ENTRIES:0]   seen;

  logic accept, upd_go, hit, evict, misuse, is_access;

  // ---------------- configuration ----------------
  lru_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  // ---------------- cell row ----------------
  // seen ripples from LRU toward MRU: high at and above the hit position.
  assign seen[0] = 1'b0;

  for (genvar i = 0; i < lru_pkg::MAX_ENTRIES; i++) begin : g_cell
    lru_pkg::id_t nbr_id;
    if (i == lru_pkg::MAX_ENTRIES - 1) begin : g_last
      assign nbr_id = cell_id[i];
    end else begin : g_mid
      assign nbr_id = cell_id[i+1];
    end
    lru_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .my_idx   (lru_pkg::idx_t'(i)),
      .next_id  (nbr_id),
      .seen_in  (seen[i]),
      .id_q     (cell_id[i]),
      .valid_q  (cell_valid[i]),
      .seen_out (seen[i+1])
    );
  end

  // ---------------- control ----------------
  assign accept    = in_ch.valid && in_ch.ready;
  assign upd_go    = (state_r == S_UPD) && (!out_valid_r || out_ch.ready);
  assign hit       = seen[lru_pkg::MAX_ENTRIES];
  assign is_access = (req_kind_r == lru_pkg::KIND_ACCESS);

  always_comb begin
    if (capacity == '0) begin
      eff_cap = lru_pkg::cnt_t'(1);
    end else if (int'(capacity) > lru_pkg::MAX_ENTRIES) begin
      eff_cap = lru_pkg::cnt_t'(lru_pkg::MAX_ENTRIES);
    end else begin
      eff_cap = lru_pkg::cnt_t'(capacity);
    end
  end

  assign misuse = is_access ? !hit : hit;
  // full tracker on a fresh insert: drop position 0
  assign evict  = !is_access && !hit && (count_r >= eff_cap) && (count_r != '0);

  always_comb begin
    ctrl.capture_en = accept;
    ctrl.id         = (state_r == S_IDLE) ? lru_pkg::id_t'(in_ch.item_id) : req_id_r;
    ctrl.shift_en   = upd_go && !misuse && (is_access || evict);
    ctrl.shift_all  = evict;
    ctrl.load_en    = upd_go && !misuse;
    // moved or evicted-and-appended: MRU is count-1; plain append: count
    ctrl.top_idx    = (is_access || evict) ? lru_pkg::idx_t'(count_r - 1'b1)
                                           : lru_pkg::idx_t'(count_r);
  end

  always_comb begin
    state_nxt     = state_r;
    req_kind_nxt  = req_kind_r;
    req_id_nxt    = req_id_r;
    count_nxt     = count_r;
    evcnt_nxt     = evcnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_evv_nxt   = out_evv_r;
    out_evid_nxt  = out_evid_r;
    out_mis_nxt   = out_mis_r;
    out_occ_nxt   = out_occ_r;
    out_cnt_nxt   = out_cnt_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_kind_nxt = in_ch.kind;
          req_id_nxt   = lru_pkg::id_t'(in_ch.item_id);
          state_nxt    = S_UPD;
        end
      end
      S_UPD: begin
        if (upd_go) begin
          if (!misuse && !is_access && !evict) begin
            count_nxt = count_r + 1'b1;
          end
          if (evict) begin
            evcnt_nxt = evcnt_r + 1'b1;
          end
          out_valid_nxt = 1'b1;
          out_evv_nxt   = evict;
          out_evid_nxt  = evict ? lru_pkg::evid_t'(cell_id[0]) : '0;
          out_mis_nxt   = misuse;
          out_occ_nxt   = lru_pkg::occ_t'(count_nxt);
          out_cnt_nxt   = evcnt_nxt;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      evcnt_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      evcnt_r     <= evcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_kind_r <= req_kind_nxt;
    req_id_r   <= req_id_nxt;
    out_evv_r  <= out_evv_nxt;
    out_evid_r <= out_evid_nxt;
    out_mis_r  <= out_mis_nxt;
    out_occ_r  <= out_occ_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.evicted_valid  = out_evv_r;
  assign out_ch.evicted_id     = out_evid_r;
  assign out_ch.misuse         = out_mis_r;
  assign out_ch.occupancy      = out_occ_r;
  assign out_ch.eviction_count = out_cnt_r;

`ifndef ASSERT_OFF
  // ids in the row are unique, so at most one cell matches
  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> $onehot0(seen[lru_pkg::MAX_ENTRIES:1] ^ seen[lru_pkg::MAX_ENTRIES-1:0]))
    else $error("more than one cell matched");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(count_r) <= lru_pkg::MAX_ENTRIES) && ($countones(cell_valid) == int'(count_r)))
    else $error("occupancy disagrees with cell valid bits");

  a_evict_keeps_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_go && evict) |=> (count_r == $past(count_r)) && (evcnt_r == $past(evcnt_r) + 1'b1))
    else $error("eviction changed occupancy or missed the counter");

  a_misuse_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_go && misuse) |=> (count_r == $past(count_r)) && (evcnt_r == $past(evcnt_r)))
    else $error("misuse changed tracker state");
`endif

endmodule

[test/lru_replacement_tracker_test.sv]
// lru_replacement_tracker_test: self-checking bench for the LRU replacement tracker.
// Drives request beats and APB register writes, predicts every result beat in-bench.
// Depends on lru_pkg, lru_if (lru_in_if, lru_out_if) and the lru_replacement_tracker rtl.
module lru_replacement_tracker_test;
  import lru_pkg::*;

  localparam int LIMIT       = 200000;  // cycle ceiling for the whole run
  localparam int PHASE_ITEMS = 140;     // random requests per capacity setting
  localparam int PHASES      = 9;

  // byte addresses: capacity is register 0, the next word is unmapped
  localparam logic [APB_ADDR_W-1:0] CAP_ADDR   = APB_ADDR_W'(REG_CAPACITY) << REG_IDX_LSB;
  localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = APB_ADDR_W'(1) << REG_IDX_LSB;

  // capacity per random phase; 0 acts as 1, 31 saturates at MAX_ENTRIES
  localparam cap_t PHASE_CAPS [PHASES] = '{5'd16, 5'd1, 5'd0, 5'd5, 5'd31,
                                           5'd2, 5'd12, 5'd8, 5'd16};

  // one result beat, as the bench predicts it
  typedef struct packed {
    logic   evicted_valid;
    evid_t  evicted_id;
    logic   misuse;
    occ_t   occupancy;
    evcnt_t eviction_count;
  } outcome_t;

  logic      clk;
  logic      rst_n;
  logic      psel;
  logic      penable;
  logic      pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  apb_data_t pwdata;
  apb_data_t prdata;
  logic      pready;

  lru_in_if  in_ch ();
  lru_out_if out_ch ();

  lru_replacement_tracker dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predicted tracker state: position 0 is the LRU entry
  id_t      lru_ids [MAX_ENTRIES];
  int       resident;
  evcnt_t   evictions;
  cap_t     cap_reg;
  outcome_t pending[$];   // predicted result beats, oldest first

  int mismatches;
  int cycles;
  bit calm;               // set for the closing phase: no idling on either side

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_resident(input id_t id);
    for (int i = 0; i < resident; i++)
      if (lru_ids[i] == id) return 1'b1;
    return 1'b0;
  endfunction

  // Applies one accepted request to the predicted list and returns its result beat.
  function automatic outcome_t advance_lru(input logic kind, input id_t id);
    outcome_t o;
    int       pos;
    int       room;
    o   = '0;
    pos = -1;
    for (int i = 0; i < resident; i++)
      if (pos < 0 && lru_ids[i] == id) pos = i;
    if (kind == KIND_ACCESS) begin
      if (pos < 0) begin
        o.misuse = 1'b1;            // access of an absent id: no change
      end else begin
        for (int i = pos; i < resident - 1; i++) lru_ids[i] = lru_ids[i + 1];
        lru_ids[resident - 1] = id;
      end
    end else if (pos >= 0) begin
      o.misuse = 1'b1;              // insert of a resident id: no change, no eviction
    end else begin
      room = (cap_reg == '0) ? 1 : ((cap_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap_reg));
      // full (or over-full after a capacity drop): drop just the oldest entry
      if (resident >= room && resident > 0) begin
        o.evicted_valid = 1'b1;
        o.evicted_id    = lru_ids[0];
        for (int i = 0; i < resident - 1; i++) lru_ids[i] = lru_ids[i + 1];
        resident--;
        evictions++;
      end
      if (resident < MAX_ENTRIES) begin
        lru_ids[resident] = id;
        resident++;
      end
    end
    o.occupancy      = occ_t'(resident);
    o.eviction_count = evictions;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycles, msg);
    mismatches++;
  endtask

  // every accepted result beat is compared with the oldest prediction
  always @(posedge clk) begin : watch_results
    outcome_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending.size() == 0) begin
        flag_mismatch($sformatf("result beat with nothing pending, occupancy %0d",
                                out_ch.occupancy));
      end else begin
        want = pending.pop_front();
        if (out_ch.evicted_valid !== want.evicted_valid)
          flag_mismatch($sformatf("evicted_valid got %0b want %0b",
                                  out_ch.evicted_valid, want.evicted_valid));
        if (out_ch.evicted_id !== want.evicted_id)
          flag_mismatch($sformatf("evicted_id got %0d want %0d",
                                  out_ch.evicted_id, want.evicted_id));
        if (out_ch.misuse !== want.misuse)
          flag_mismatch($sformatf("misuse got %0b want %0b", out_ch.misuse, want.misuse));
        if (out_ch.occupancy !== want.occupancy)
          flag_mismatch($sformatf("occupancy got %0d want %0d",
                                  out_ch.occupancy, want.occupancy));
        if (out_ch.eviction_count !== want.eviction_count)
          flag_mismatch($sformatf("eviction_count got %0d want %0d",
                                  out_ch.eviction_count, want.eviction_count));
      end
    end
  end

  // hard stop if the run hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("lru_replacement_tracker_test: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: ready drops in random bursts, none once calm is set
  // ---------------------------------------------------------------------------

  initial begin
    out_ch.ready <= 1'b1;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Request side. All tasks start and end right after a rising edge.
  // valid is left high after a beat so back-to-back beats need no extra edge;
  // pause_in and drain_results are the only places that lower it.
  // ---------------------------------------------------------------------------

  task automatic pause_in(input int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // hold off the sender until every predicted beat has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending.size() != 0);
  endtask

  task automatic send_op(input logic kind, input id_t id);
    if (!calm && $urandom_range(0, 4) == 0) pause_in($urandom_range(1, 12));
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= kind;
    in_ch.item_id <= id;
    do @(posedge clk); while (!in_ch.ready);
    pending.push_back(advance_lru(kind, id));
  endtask

  // half the time a resident id, else a small pool (many repeats) or any id
  function automatic id_t pick_id();
    int roll;
    roll = $urandom_range(0, 9);
    if (resident > 0 && roll < 5) return lru_ids[$urandom_range(0, resident - 1)];
    if (roll < 8) return id_t'($urandom_range(0, 23));
    return id_t'($urandom_range(0, 255));
  endfunction

  // mostly legal traffic (hit -> access, miss -> insert); one in five is a misuse
  task automatic send_random_op();
    id_t  id;
    logic kind;
    logic hit;
    id  = pick_id();
    hit = is_resident(id);
    if ($urandom_range(0, 4) == 0) kind = hit ? KIND_INSERT : KIND_ACCESS;
    else                           kind = hit ? KIND_ACCESS : KIND_INSERT;
    send_op(kind, id);
  endtask

  // ---------------------------------------------------------------------------
  // APB: setup, then access until pready is seen, then an idle cycle
  // ---------------------------------------------------------------------------

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input apb_data_t data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr[APB_ADDR_W-1:REG_IDX_LSB] == REG_CAPACITY) cap_reg = data[CAP_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read_check(input logic [APB_ADDR_W-1:0] addr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[CAP_W-1:0] !== cap_reg)
      flag_mismatch($sformatf("capacity read got %0d want %0d", prdata[CAP_W-1:0], cap_reg));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // only the low bits hold capacity; the rest of the word carries junk
  task automatic set_capacity(input cap_t cap);
    apb_data_t data;
    data = $urandom();
    data[CAP_W-1:0] = cap;
    apb_write(CAP_ADDR, data);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset value, and a write to the unmapped word leaves capacity alone
  task automatic check_register_port();
    apb_read_check(CAP_ADDR);
    apb_write(SPARE_ADDR, $urandom());
    apb_read_check(CAP_ADDR);
  endtask

  task automatic check_empty_access();
    send_op(KIND_ACCESS, id_t'(5));
    drain_results();
  endtask

  // small capacity from near-empty, zero capacity, then saturating capacity
  task automatic check_capacity_limits();
    set_capacity(5'd2);
    send_op(KIND_INSERT, id_t'(9));
    send_op(KIND_INSERT, id_t'(10));
    send_op(KIND_INSERT, id_t'(11));   // full at 2: evicts 9
    drain_results();
    set_capacity(5'd0);                // behaves as 1, two resident
    send_op(KIND_INSERT, id_t'(12));   // evicts one, occupancy stays 2
    drain_results();
    set_capacity(5'd31);
    apb_read_check(CAP_ADDR);
  endtask

  // extreme ids, misuse both ways, hits at LRU, middle and MRU positions
  task automatic check_basic_ops();
    send_op(KIND_INSERT, id_t'(0));
    send_op(KIND_INSERT, id_t'(255));
    send_op(KIND_INSERT, id_t'(255));  // already resident
    send_op(KIND_ACCESS, id_t'(0));    // middle of the list
    send_op(KIND_ACCESS, id_t'(77));   // absent
    send_op(KIND_ACCESS, id_t'(11));   // oldest entry
    send_op(KIND_ACCESS, id_t'(11));   // already newest
    drain_results();
  endtask

  // phases of random traffic, capacity rewritten between phases
  task automatic run_random_traffic();
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      if (p == PHASES - 1) calm = 1'b1;
      if (p % 3 == 1) apb_write(SPARE_ADDR, $urandom());
      set_capacity(PHASE_CAPS[p]);
      apb_read_check(CAP_ADDR);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // one mid-phase stop with the pipe fully empty
        if (p == 3 && n == PHASE_ITEMS / 2) drain_results();
        send_random_op();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.kind    <= KIND_ACCESS;
    in_ch.item_id <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    for (int i = 0; i < MAX_ENTRIES; i++) lru_ids[i] = '0;
    resident   = 0;
    evictions  = '0;
    cap_reg    = CAP_RESET;
    mismatches = 0;
    cycles     = 0;
    calm       = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    check_register_port();
    check_empty_access();
    check_capacity_limits();
    check_basic_ops();
    run_random_traffic();

    drain_results();
    repeat (16) @(posedge clk);   // catch any stray beat after the last one
    if (mismatches == 0) begin
      $display("lru_replacement_tracker_test: clean");
    end else begin
      $display("lru_replacement_tracker_test: errors");
    end
    $finish;
  end

endmodule
